FILE: design/gvgc_pkg.sv
package gvgc_pkg;

  localparam int FREQ_W    = 30;
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 30;

  // request modes
  localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_RATE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_THRESHOLD = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET   = 16'd524;
  localparam logic [FREQ_W-1:0] THRESH_RESET = 30'd6554;

  // one voice as stored in the state memory
  typedef struct packed {
    logic [FREQ_W-1:0] cur;
    logic [FREQ_W-1:0] tgt;
    logic [FREQ_W-1:0] ret;
    logic              glide;
    logic              sound;
  } voice_entry_t;

  localparam int ENTRY_W = $bits(voice_entry_t);

  // request info and settings handed to the update datapath
  typedef struct packed {
    logic [1:0]        mode;
    logic [6:0]        note;
    logic              glide_en;
    logic [RATE_W-1:0] rate;
    logic [FREQ_W-1:0] thr;
  } upd_cmd_t;

  // top octave (notes 120..131), Q14.16 Hz
  function automatic logic [FREQ_W-1:0] pitch_top(input logic [3:0] k);
    logic [FREQ_W-1:0] r;
    case (k)
      4'd0:    r = 30'd548668578;
      4'd1:    r = 30'd581294109;
      4'd2:    r = 30'd615859655;
      4'd3:    r = 30'd652480576;
      4'd4:    r = 30'd691279090;
      4'd5:    r = 30'd732384684;
      4'd6:    r = 30'd775934544;
      4'd7:    r = 30'd822074013;
      4'd8:    r = 30'd870957077;
      4'd9:    r = 30'd922746880;
      4'd10:   r = 30'd977616265;
      4'd11:   r = 30'd1035748353;
      default: r = '0;
    endcase
    return r;
  endfunction

  // note -> pitch: octave by reciprocal multiply (n*43>>9 is exact for n < 128),
  // then shift the top-octave value down with round half up
  function automatic logic [FREQ_W-1:0] pitch_of(input logic [6:0] n);
    logic [12:0]       prod;
    logic [3:0]        oct;
    logic [6:0]        rem;
    logic [3:0]        sh;
    logic [FREQ_W:0]   top;
    logic [FREQ_W:0]   rnd;
    logic [FREQ_W-1:0] r;
    prod = 13'(n) * 13'd43;
    oct  = prod[12:9];
    rem  = n - 7'(oct) * 7'd12;
    sh   = 4'd10 - oct;
    top  = {1'b0, pitch_top(rem[3:0])};
    if (sh == 4'd0) begin
      r = top[FREQ_W-1:0];
    end else begin
      rnd = (top + ((FREQ_W+1)'(1) << (sh - 4'd1))) >> sh;
      r   = rnd[FREQ_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/gvgc_ram.sv
module gvgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gvgc_update.sv
module gvgc_update (
  input  logic                   clk,
  input  logic                   capture,
  input  gvgc_pkg::upd_cmd_t     cmd,
  input  gvgc_pkg::voice_entry_t entry_in,
  output gvgc_pkg::voice_entry_t entry_out
);
  import gvgc_pkg::*;

  // first stage: difference, product, snap compare, ROM lookup
  logic signed [FREQ_W:0]     diff;
  logic        [FREQ_W:0]     mag;
  logic signed [FREQ_W+17:0]  prod;

  voice_entry_t               ent;
  logic [1:0]                 mode;
  logic                       glide_en;
  logic signed [FREQ_W+17:0]  prod_q;
  logic                       snap;
  logic                       moving;
  logic [FREQ_W-1:0]          pitch;

  always_comb begin
    diff = $signed({1'b0, entry_in.tgt}) - $signed({1'b0, entry_in.cur});
    mag  = diff[FREQ_W] ? (FREQ_W+1)'(-diff) : diff;
    prod = (FREQ_W+18)'(diff) * $signed((FREQ_W+18)'(cmd.rate));
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      ent      <= entry_in;
      mode     <= cmd.mode;
      glide_en <= cmd.glide_en;
      prod_q   <= prod;
      snap     <= mag < {1'b0, cmd.thr};
      moving   <= entry_in.glide && (entry_in.cur != entry_in.tgt);
      pitch    <= pitch_of(cmd.note);
    end
  end

  // second stage: apply the step (arithmetic shift floors) and new voice state
  logic signed [31:0] step;
  logic        [31:0] sum;

  always_comb begin
    step      = prod_q[47:16];
    sum       = {2'b00, ent.cur} + 32'(step);
    entry_out = ent;
    case (mode)
      MODE_NOTE_ON: begin
        if (glide_en && ent.sound) begin
          entry_out.ret   = ent.cur;
          entry_out.tgt   = pitch;
          entry_out.glide = 1'b1;
        end else begin
          entry_out.cur   = pitch;
          entry_out.tgt   = pitch;
          entry_out.ret   = pitch;
          entry_out.glide = 1'b0;
        end
        entry_out.sound = 1'b1;
      end
      MODE_NOTE_OFF: begin
        entry_out.sound = 1'b0;
        if (ent.glide && (ent.ret != '0)) begin
          entry_out.tgt = ent.ret;
        end
      end
      MODE_TICK: begin
        if (moving) begin
          if (snap) begin
            entry_out.cur   = ent.tgt;
            entry_out.glide = 1'b0;
          end else begin
            entry_out.cur = sum[FREQ_W-1:0];
          end
        end
      end
      default: begin
        entry_out = ent;
      end
    endcase
  end

endmodule

FILE: design/four_voice_glide_controller_core.sv
// Each request is accepted in IDLE; every voice it visits then passes through
//   READ, CALC and WRITE (read / compute / write-back through the state memory),
//   and each result is registered at write-back. Note on / note off visit one
//   voice, a tick all of them; glide-off ticks and ignored requests: no results.
// Reset: synchronous, active high; clears config to defaults and all voice
//   valid bits, so every voice reads back as zero until first written.
module four_voice_glide_controller_core #(
  parameter int VOICES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       mode,
  input  logic [1:0]                       voice,
  input  logic [6:0]                       note,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_voice,
  output logic [gvgc_pkg::FREQ_W-1:0]      frequency,
  output logic                             gate,
  output logic                             gliding,
  output logic                             last,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gvgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gvgc_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import gvgc_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // ---------------------------------------------------------------------------
  logic              glide_enable;
  logic [RATE_W-1:0] glide_rate;
  logic [FREQ_W-1:0] snap_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glide_enable   <= 1'b0;
      glide_rate     <= RATE_RESET;
      snap_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GLIDE_ENABLE:   glide_enable   <= cfg_data[0];
        CFG_GLIDE_RATE:     glide_rate     <= cfg_data[RATE_W-1:0];
        CFG_SNAP_THRESHOLD: snap_threshold <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. One request at a time; each voice visited goes through
  // READ (memory address out), CALC (data back, product registered) and
  // WRITE (write back + load result register). The next read of any voice
  // starts only after the write-back edge, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [VIDX_W-1:0] idx;
  logic              multi;      // tick: walk all voices
  logic [1:0]        req_mode;
  logic [6:0]        req_note;
  logic              vld_q;      // valid bit of the entry being read
  logic [VOICES-1:0] vld;        // entry written since reset

  logic [31:0]       voice_ext;
  logic              in_acc;
  logic              take_tick;
  logic              take_note;
  logic              out_free;
  logic              wb;
  logic              wb_last;

  assign voice_ext = {30'd0, voice};
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign take_tick = (mode == MODE_TICK) && glide_enable;
  assign take_note = ((mode == MODE_NOTE_ON) || (mode == MODE_NOTE_OFF)) &&
                     (voice_ext < VOICES);
  assign out_free  = !out_valid || out_ready;
  assign wb        = (state == ST_WRITE) && out_free;
  assign wb_last   = !multi || (32'(idx) == VOICES - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && (take_tick || take_note)) state_next = ST_READ;
      ST_READ:  state_next = ST_CALC;
      ST_CALC:  state_next = ST_WRITE;
      ST_WRITE: if (wb) state_next = wb_last ? ST_IDLE : ST_READ;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vld   <= '0;
      multi <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        multi <= take_tick;
        idx   <= take_tick ? '0 : voice_ext[VIDX_W-1:0];
      end else if (wb && !wb_last) begin
        idx <= idx + VIDX_W'(1);
      end
      if (wb) begin
        vld[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode <= mode;
      req_note <= note;
    end
    if (state == ST_READ) begin
      vld_q <= vld[idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Voice state memory and update datapath
  // ---------------------------------------------------------------------------
  voice_entry_t ram_rdata;
  voice_entry_t entry_in;
  voice_entry_t entry_out;
  upd_cmd_t     cmd;

  gvgc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VOICES),
    .AW    (VIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wb),
    .waddr (idx),
    .wdata (entry_out),
    .re    (state == ST_READ),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // never-written voices read as all zero
  assign entry_in = vld_q ? ram_rdata : '0;

  assign cmd.mode     = req_mode;
  assign cmd.note     = req_note;
  assign cmd.glide_en = glide_enable;
  assign cmd.rate     = glide_rate;
  assign cmd.thr      = snap_threshold;

  gvgc_update u_update (
    .clk       (clk),
    .capture   (state == ST_CALC),
    .cmd       (cmd),
    .entry_in  (entry_in),
    .entry_out (entry_out)
  );

  // ---------------------------------------------------------------------------
  // Result register: holds one result so the sequencer keeps going while the
  // consumer is slow; write-back waits only when it is still full.
  // ---------------------------------------------------------------------------
  logic [VIDX_W+1:0] idx_ext;
  assign idx_ext = {2'b00, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb) begin
      out_voice <= idx_ext[1:0];
      frequency <= entry_out.cur;
      gate      <= entry_out.sound;
      gliding   <= entry_out.glide;
      last      <= wb_last;
    end
  end

endmodule

FILE: design/gvgc_checker.sv
module gvgc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     mode,
  input logic [1:0]                     voice,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_voice,
  input logic [gvgc_pkg::FREQ_W-1:0]    frequency,
  input logic                           gate,
  input logic                           gliding,
  input logic                           last
);
  import gvgc_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frequency) && $stable(out_voice) &&
      $stable(gate) && $stable(gliding) && $stable(last))
    else $error("result changed while stalled");

  // while a non-final result is out, the request it belongs to is unfinished
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("new request taken before final result");

  // a note on for voice 0 always causes work, so the block is busy next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_NOTE_ON) && (voice == 2'd0) |=> !in_ready)
    else $error("note on dropped");

endmodule

bind four_voice_glide_controller_core gvgc_checker u_gvgc_checker (.*);
